// ----- hdl/qwspwm_pkg.sv -----
// Shared widths, codes and item types for the quarter-wave sine-PWM sequencer.
// No dependencies; the interface file and the sequencer import this package.
package qwspwm_pkg;

  localparam int TABLE_DEPTH_DEF = 256;

  localparam int CMD_W    = 1;
  localparam int IDX_W    = 8;
  localparam int DUTY_W   = 12;
  localparam int QP_W     = 9;
  localparam int STEP_W   = 8;
  localparam int PHASE_W  = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;

  // Longest quarter the step counter supports
  localparam int QP_LIMIT = 256;

  localparam logic [CMD_W-1:0] CMD_TICK  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_QUARTER_POINTS = 1'b1;

  localparam logic [PHASE_W-1:0] Q_RISE_POS = 2'd0;
  localparam logic [PHASE_W-1:0] Q_FALL_POS = 2'd1;
  localparam logic [PHASE_W-1:0] Q_RISE_NEG = 2'd2;
  localparam logic [PHASE_W-1:0] Q_FALL_NEG = 2'd3;

  typedef logic [DUTY_W-1:0]  duty_t;
  typedef logic [IDX_W-1:0]   index_t;
  typedef logic [PHASE_W-1:0] phase_t;

endpackage

// ----- hdl/qwspwm_if.sv -----
// Valid/ready channels for request items and result items.
// Depends on qwspwm_pkg.
interface qwspwm_in_if;
  import qwspwm_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CMD_W-1:0]       command;
  index_t                 table_index;
  duty_t                  table_value;

  modport source (output valid, output command, output table_index, output table_value,
                  input ready);
  modport sink   (input valid, input command, input table_index, input table_value,
                  output ready);
endinterface

interface qwspwm_out_if;
  import qwspwm_pkg::*;

  logic   valid;
  logic   ready;
  duty_t  duty;
  logic   main_on;
  logic   comp_on;
  phase_t quarter;

  modport source (output valid, output duty, output main_on, output comp_on, output quarter,
                  input ready);
  modport sink   (input valid, input duty, input main_on, input comp_on, input quarter,
                  output ready);
endinterface

// ----- hdl/qwspwm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qwspwm_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/quarter_wave_spwm_sequencer.sv -----
// Quarter-wave sine-PWM sequencer: plays a duty table as a full sine period.
// A tick request's result is registered in the read stage, then in the result register.
// Throughput: one request per cycle while the result side is not back-pressured, set by the single table read port.
// Table writes give no result. Reset (rst, synchronous) returns to the first
// rising quarter, step 0, both halves armed, both outputs off; table undefined.
module quarter_wave_spwm_sequencer #(
  parameter int TABLE_DEPTH = qwspwm_pkg::TABLE_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  qwspwm_in_if.sink                        in_item,
  qwspwm_out_if.source                     result,
  input  logic                             cfg_write,
  input  logic [qwspwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [qwspwm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import qwspwm_pkg::*;

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int PMAX_I = (TABLE_DEPTH < QP_LIMIT) ? TABLE_DEPTH : QP_LIMIT;
  localparam logic [QP_W-1:0] P_MAX = QP_W'(PMAX_I);
  localparam logic [IDX_W+AW:0] DEPTH_CMP = (IDX_W+AW+1)'(TABLE_DEPTH);

  // Configuration
  logic            output_enable;
  logic [QP_W-1:0] quarter_points;

  // Sequencer state
  phase_t            phase, phase_next;
  logic [STEP_W-1:0] step, step_next;
  logic              high_armed, high_armed_next;
  logic              low_armed, low_armed_next;
  logic              main_enabled, main_enabled_next;
  logic              comp_enabled, comp_enabled_next;

  // Read stage
  logic   s1_valid, s1_zero, s1_main, s1_comp;
  phase_t s1_quarter;
  duty_t  ram_rdata;

  logic in_acc, is_tick, is_write, wr_ok, s1_adv;
  logic [QP_W-1:0] p_used, s_sat, s_inc, idx;
  logic [AW-1:0]   raddr, waddr;

  assign in_acc   = in_item.valid && in_item.ready;
  assign is_tick  = in_item.command == CMD_TICK;
  assign is_write = in_item.command == CMD_WRITE;
  assign s1_adv   = s1_valid && (!result.valid || result.ready);
  assign in_item.ready = !s1_valid || s1_adv;

  assign wr_ok = (IDX_W+AW+1)'(in_item.table_index) < DEPTH_CMP;
  assign waddr = AW'(in_item.table_index);

  always_comb begin
    if (quarter_points == '0) begin
      p_used = QP_W'(1);
    end else if (quarter_points > P_MAX) begin
      p_used = P_MAX;
    end else begin
      p_used = quarter_points;
    end
    // Clamp a step left over from a longer quarter
    if ({1'b0, step} >= p_used) begin
      s_sat = p_used - QP_W'(1);
    end else begin
      s_sat = {1'b0, step};
    end
    idx   = phase[0] ? (p_used - QP_W'(1) - s_sat) : s_sat;
    raddr = AW'(idx[IDX_W-1:0]);
    s_inc = s_sat + QP_W'(1);

    phase_next        = phase;
    step_next         = step;
    high_armed_next   = high_armed;
    low_armed_next    = low_armed;
    main_enabled_next = main_enabled;
    comp_enabled_next = comp_enabled;

    if (!output_enable) begin
      main_enabled_next = 1'b0;
      comp_enabled_next = 1'b0;
    end else begin
      if (phase == Q_RISE_POS && high_armed) begin
        comp_enabled_next = 1'b0;
        main_enabled_next = 1'b1;
        high_armed_next   = 1'b0;
        low_armed_next    = 1'b1;
      end else if (phase == Q_RISE_NEG && low_armed) begin
        main_enabled_next = 1'b0;
        comp_enabled_next = 1'b1;
        low_armed_next    = 1'b0;
        high_armed_next   = 1'b1;
      end
      if (s_inc >= p_used) begin
        step_next  = '0;
        phase_next = phase + PHASE_W'(1);
      end else begin
        step_next = s_inc[STEP_W-1:0];
      end
    end
  end

  qwspwm_ram #(
    .WIDTH (DUTY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (in_acc && is_write && wr_ok),
    .waddr (waddr),
    .wdata (in_item.table_value),
    .re    (in_acc && is_tick && output_enable),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enable  <= 1'b0;
      quarter_points <= QP_W'(200);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_OUTPUT_ENABLE:  output_enable  <= cfg_data[0];
        REG_QUARTER_POINTS: quarter_points <= cfg_data[QP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= Q_RISE_POS;
      step         <= '0;
      high_armed   <= 1'b1;
      low_armed    <= 1'b1;
      main_enabled <= 1'b0;
      comp_enabled <= 1'b0;
    end else if (in_acc && is_tick) begin
      phase        <= phase_next;
      step         <= step_next;
      high_armed   <= high_armed_next;
      low_armed    <= low_armed_next;
      main_enabled <= main_enabled_next;
      comp_enabled <= comp_enabled_next;
    end
  end

  // Read stage: the table data lands alongside these flags
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_item.ready) begin
      s1_valid <= in_acc && is_tick;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_tick) begin
      s1_zero    <= !output_enable;
      s1_main    <= main_enabled_next;
      s1_comp    <= comp_enabled_next;
      s1_quarter <= phase;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_adv) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      result.duty    <= s1_zero ? '0 : ram_rdata;
      result.main_on <= s1_main;
      result.comp_on <= s1_comp;
      result.quarter <= s1_quarter;
    end
  end

`ifndef SYNTHESIS
  a_outputs_exclusive : assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.main_on && result.comp_on))
    else $error("main and complementary outputs both on");

  a_state_exclusive : assert property (@(posedge clk) disable iff (rst)
    !(main_enabled && comp_enabled))
    else $error("main and complementary enables both set");

  a_one_half_armed : assert property (@(posedge clk) disable iff (rst)
    high_armed || low_armed)
    else $error("both half-cycle arm flags cleared");

  a_write_no_result : assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_write) |=> !s1_valid)
    else $error("table write produced a pending result");
`endif

endmodule
